// ===== hw/rtl/ipft_pkg.sv =====
// ipft_pkg: shared types and constants for the ip fragment port tracker
// no dependencies
package ipft_pkg;

  localparam logic [15:0] FlagDf     = 16'h4000;
  localparam logic [15:0] FlagMf     = 16'h2000;
  localparam logic [15:0] OffsetMask = 16'h1FFF;
  localparam logic [7:0]  LifetimeReset = 8'd3;
  localparam logic [1:0]  TypeUpload   = 2'd0;
  localparam logic [1:0]  TypeDownload = 2'd1;
  localparam logic        RegLifetime = 1'b0;

  typedef struct packed {
    logic [1:0]  packet_type;
    logic [31:0] interface_number;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [15:0] ip_ident;
    logic [15:0] flags_offset;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [31:0] capture_length;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic        parse_ok;
    logic        is_download;
    logic [31:0] out_interface;
    logic [7:0]  out_protocol;
    logic [31:0] out_local_address;
    logic [31:0] out_remote_address;
    logic [15:0] out_local_port;
    logic [15:0] out_remote_port;
    logic [31:0] out_length;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StUpdate,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic update;
  } cmd_t;

endpackage

// ===== hw/rtl/ipft_ctrl.sv =====
// ipft_ctrl: sequencer for the fragment tracker
// depends on ipft_pkg
module ipft_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output ipft_pkg::cmd_t     cmd_o
);

  ipft_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipft_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipft_pkg::StIdle:   if (in_valid_i) state_d = ipft_pkg::StMatch;
      ipft_pkg::StMatch:  state_d = ipft_pkg::StUpdate;
      ipft_pkg::StUpdate: state_d = ipft_pkg::StOut;
      ipft_pkg::StOut:    if (!out_stall_i) state_d = ipft_pkg::StIdle;
      default:            state_d = ipft_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ipft_pkg::StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ipft_pkg::StMatch:  cmd_o.match = 1'b1;
      ipft_pkg::StUpdate: cmd_o.update = 1'b1;
      ipft_pkg::StOut:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ipft_datapath.sv =====
// ipft_datapath: fragment table, match, allocate, expiry and record build
// depends on ipft_pkg
module ipft_datapath #(
  parameter int unsigned TableEntries = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipft_pkg::cmd_t      cmd_i,
  input  ipft_pkg::in_item_t  in_item_i,
  input  logic [7:0]          lifetime_i,
  output ipft_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  ipft_pkg::in_item_t item_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0] count_q;
  logic [31:0] stamp_q [TableEntries];
  logic [31:0] src_q   [TableEntries];
  logic [31:0] dst_q   [TableEntries];
  logic [15:0] id_q    [TableEntries];
  logic [15:0] sp_q    [TableEntries];
  logic [15:0] dp_q    [TableEntries];

  logic [TableEntries-1:0] hit_q;
  logic [TableEntries-1:0] hit_d;

  // classification of the held item
  logic df, mf, off_zero, is_first, is_later;
  assign df       = |(item_q.flags_offset & ipft_pkg::FlagDf);
  assign mf       = |(item_q.flags_offset & ipft_pkg::FlagMf);
  assign off_zero = ~|(item_q.flags_offset & ipft_pkg::OffsetMask);
  assign is_first = !df && mf && off_zero;
  assign is_later = !df && !off_zero;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_d[i] = valid_q[i] && id_q[i] == item_q.ip_ident &&
                 src_q[i] == item_q.source_address && dst_q[i] == item_q.target_address;
    end
  end

  // lowest set bit of hit and of free mask
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            hit_any, free_any;
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IdxW'(i);
        hit_any = 1'b1;
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic ok;
  logic [15:0] sport, dport;
  logic [TableEntries-1:0] valid_next;
  logic alloc, release_hit;
  always_comb begin
    ok          = 1'b1;
    sport       = item_q.src_port_in;
    dport       = item_q.dst_port_in;
    alloc       = 1'b0;
    release_hit = 1'b0;
    if (is_first) begin
      // table full once the occupancy count reaches the table size
      if (free_any && count_q < CntW'(TableEntries)) alloc = 1'b1;
      else ok = 1'b0;
    end else if (is_later) begin
      if (hit_any) begin
        sport = sp_q[hit_idx];
        dport = dp_q[hit_idx];
        release_hit = !mf;
      end else begin
        ok = 1'b0;
      end
    end
    if (item_q.packet_type != ipft_pkg::TypeUpload &&
        item_q.packet_type != ipft_pkg::TypeDownload) ok = 1'b0;
    valid_next = valid_q;
    if (alloc) valid_next[free_idx] = 1'b1;
    if (release_hit) valid_next[hit_idx] = 1'b0;
    // expiry, a just stored entry has age zero
    for (int i = 0; i < TableEntries; i++) begin
      if (alloc && free_idx == IdxW'(i)) begin
        if (lifetime_i == 8'd0) valid_next[i] = 1'b0;
      end else if (valid_next[i] &&
                   (item_q.now_seconds - stamp_q[i]) >= {24'd0, lifetime_i}) begin
        valid_next[i] = 1'b0;
      end
    end
  end

  logic down;
  assign down = item_q.packet_type == ipft_pkg::TypeDownload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.update) begin
      valid_q <= valid_next;
      count_q <= CntW'($countones(valid_next));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.match) hit_q <= hit_d;
    if (cmd_i.update) begin
      if (alloc) begin
        stamp_q[free_idx] <= item_q.now_seconds;
        src_q[free_idx]   <= item_q.source_address;
        dst_q[free_idx]   <= item_q.target_address;
        id_q[free_idx]    <= item_q.ip_ident;
        sp_q[free_idx]    <= item_q.src_port_in;
        dp_q[free_idx]    <= item_q.dst_port_in;
      end
      if (ok) begin
        out_item_o.parse_ok           <= 1'b1;
        out_item_o.is_download        <= down;
        out_item_o.out_interface      <= item_q.interface_number;
        out_item_o.out_protocol       <= item_q.ip_protocol;
        out_item_o.out_local_address  <= down ? item_q.target_address
                                              : item_q.source_address;
        out_item_o.out_remote_address <= down ? item_q.source_address
                                              : item_q.target_address;
        out_item_o.out_local_port     <= down ? dport : sport;
        out_item_o.out_remote_port    <= down ? sport : dport;
        out_item_o.out_length         <= item_q.capture_length;
      end else begin
        out_item_o <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/ip_fragment_port_tracker_unit.sv =====
// ip_fragment_port_tracker_unit: top level of the fragment port tracker
// depends on ipft_pkg, ipft_ctrl, ipft_datapath
//
//   channel   direction  handshake            payload
//   in        input      in_valid_i/in_stall_o    ipft_pkg::in_item_t
//   out       output     out_valid_o/out_stall_i  ipft_pkg::out_item_t
//   cfg       input      apb write/read        lifetime_seconds at 0x0
//
// each transaction runs through capture, parallel match over all entries,
// update with allocation and expiry, then present, held through output stalls;
// one item is in flight at a time; input stall is high from capture until
// the result transaction completes
// reset clears all valid bits and count and sets lifetime to 3; stored fields are not reset
module ip_fragment_port_tracker_unit #(
  parameter int unsigned TableEntries = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ipft_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ipft_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] lifetime_q;
  ipft_pkg::cmd_t cmd;

  // single register at byte address zero
  logic reg_sel;
  assign reg_sel = paddr == {ipft_pkg::RegLifetime, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= ipft_pkg::LifetimeReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      lifetime_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? {24'd0, lifetime_q} : 32'd0;

  ipft_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .out_stall_i,
    .in_stall_o, .out_valid_o, .cmd_o(cmd)
  );

  ipft_datapath #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_item_i,
    .lifetime_i(lifetime_q), .out_item_o
  );

endmodule

// ===== hw/rtl/ipft_checker.sv =====
// ipft_checker: port level checks for the fragment tracker
// depends on ipft_pkg; bound to ip_fragment_port_tracker_unit
module ipft_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ipft_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open with result pending");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##3 out_valid_o)
    else $error("result late");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.parse_ok |-> out_item_o == '0)
    else $error("failure record not zero");

endmodule

bind ip_fragment_port_tracker_unit ipft_checker u_ipft_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o
);
